[hdl/pti_pkg.sv]
// ----------------------------------------------------------------------------
// pti_pkg: shared types and constants of the periodic table interpolator
// Field widths, table geometry, register indexes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pti_pkg;

    // table geometry
    localparam int NUM_ACTUATORS = 8;
    localparam int CACHE_POINTS  = 128;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRAC_BITS     = 16;

    localparam int TIME_W      = 32;
    localparam int CH_W        = 3;                          // channel field
    localparam int PT_W        = 7;                          // point index field
    localparam int PTS_W       = 8;                          // points_in_use register
    localparam int ACT_W       = 4;                          // actuators_in_use register
    localparam int ADDR_W      = CH_W + PT_W;
    localparam int TABLE_DEPTH = NUM_ACTUATORS * CACHE_POINTS;
    localparam int PROD_W      = TIME_W + PTS_W;             // elapsed * points
    localparam int QUOT_BITS   = PT_W + FRAC_BITS;           // point index . fraction
    localparam int CNT_W       = 6;                          // divider step counter
    localparam int MIX_W       = SAMPLE_WIDTH + 1;           // sample difference
    localparam int MPROD_W     = 2 * MIX_W;                  // difference * fraction

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd2;

    localparam logic [PTS_W-1:0]  RST_POINTS = 8'd100;
    localparam logic [ACT_W-1:0]  RST_ACTS   = 4'd8;
    localparam logic [TIME_W-1:0] RST_LEN    = 32'd5000;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TIME  = 1'b1;

    typedef struct packed {
        logic                           command;
        logic [CH_W-1:0]                channel;
        logic [PT_W-1:0]                point_index;
        logic signed [SAMPLE_WIDTH-1:0] point_value;
        logic [TIME_W-1:0]              now_time;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0]                out_channel;
        logic signed [SAMPLE_WIDTH-1:0] drive_value;
        logic                           last_channel;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAP,
        S_MOD,
        S_MULP,
        S_PSTART,
        S_FRAC,
        S_RDA,
        S_RDB,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic wr_en;        // store one table sample
        logic take_time;    // latch time, config snapshot, first start
        logic load_e;       // elapsed time into register
        logic mod_start;    // divider: elapsed mod cycle length
        logic mod_load;     // wrapped elapsed and advanced start
        logic mul_p;        // elapsed * points
        logic frac_start;   // divider: point index and fraction
        logic frac_load;    // point pair and fraction, channel 0
        logic rd_b;         // address second point, keep first sample
        logic mul;          // difference * fraction
        logic out_load;     // result into output register
    } t_cmd;

    typedef struct packed {
        logic e_ge_len;
        logic div_done;
        logic out_free;
        logic ch_last;
    } t_stat;

endpackage

`default_nettype wire

[hdl/pti_div.sv]
// ----------------------------------------------------------------------------
// pti_div: restoring divider, one quotient bit per cycle
// Starts from a given partial remainder (below the divisor) and shifts in a
// given number of dividend bits, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module pti_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pti_pkg::TIME_W-1:0]  i_init_rem,
    input  wire logic [pti_pkg::TIME_W-1:0]  i_bits,
    input  wire logic [pti_pkg::CNT_W-1:0]   i_count,
    input  wire logic [pti_pkg::TIME_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [pti_pkg::TIME_W-1:0]       o_quot,
    output logic [pti_pkg::TIME_W-1:0]       o_rem
);

    logic [pti_pkg::TIME_W-1:0] r_rem;
    logic [pti_pkg::TIME_W-1:0] r_bits;
    logic [pti_pkg::TIME_W-1:0] r_quot;
    logic [pti_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [pti_pkg::TIME_W:0]   trial;
    logic [pti_pkg::TIME_W:0]   diff;
    logic                       fits;

    assign trial = {r_rem, r_bits[pti_pkg::TIME_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign fits  = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == pti_pkg::CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - pti_pkg::CNT_W'(1);
                if (r_cnt == pti_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_init_rem;
            r_bits <= i_bits;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[pti_pkg::TIME_W-1:0] : trial[pti_pkg::TIME_W-1:0];
            r_quot <= {r_quot[pti_pkg::TIME_W-2:0], fits};
            r_bits <= {r_bits[pti_pkg::TIME_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[hdl/pti_dp.sv]
// ----------------------------------------------------------------------------
// pti_dp: datapath of the periodic table interpolator
// Config registers, sample table, timing registers, shared divider,
// interpolation multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pti_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pti_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pti_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire pti_pkg::t_in                    i_in_data,
    input  wire pti_pkg::t_cmd                   i_cmd,
    output pti_pkg::t_stat                       o_stat,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output pti_pkg::t_out                        o_out_data
);

    // configuration
    logic [pti_pkg::PTS_W-1:0]  r_cfg_pts;
    logic [pti_pkg::ACT_W-1:0]  r_cfg_acts;
    logic [pti_pkg::TIME_W-1:0] r_cfg_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pts  <= pti_pkg::RST_POINTS;
            r_cfg_acts <= pti_pkg::RST_ACTS;
            r_cfg_len  <= pti_pkg::RST_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pti_pkg::CFG_POINTS: r_cfg_pts  <= i_cfg_data[pti_pkg::PTS_W-1:0];
                pti_pkg::CFG_ACTS:   r_cfg_acts <= i_cfg_data[pti_pkg::ACT_W-1:0];
                pti_pkg::CFG_LEN:    r_cfg_len  <= i_cfg_data[pti_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped config
    logic [pti_pkg::TIME_W-1:0] len_sat;
    logic [pti_pkg::PTS_W-1:0]  pts_sat;
    logic [pti_pkg::ACT_W-1:0]  acts_sat;

    always_comb begin
        len_sat = (r_cfg_len == '0) ? pti_pkg::TIME_W'(1) : r_cfg_len;
        if (r_cfg_pts < pti_pkg::PTS_W'(2)) begin
            pts_sat = pti_pkg::PTS_W'(2);
        end else if (r_cfg_pts > pti_pkg::PTS_W'(pti_pkg::CACHE_POINTS)) begin
            pts_sat = pti_pkg::PTS_W'(pti_pkg::CACHE_POINTS);
        end else begin
            pts_sat = r_cfg_pts;
        end
        if (r_cfg_acts < pti_pkg::ACT_W'(1)) begin
            acts_sat = pti_pkg::ACT_W'(1);
        end else if (r_cfg_acts > pti_pkg::ACT_W'(pti_pkg::NUM_ACTUATORS)) begin
            acts_sat = pti_pkg::ACT_W'(pti_pkg::NUM_ACTUATORS);
        end else begin
            acts_sat = r_cfg_acts;
        end
    end

    // sample table
    logic [pti_pkg::SAMPLE_WIDTH-1:0] mem [pti_pkg::TABLE_DEPTH];
    logic [pti_pkg::ADDR_W-1:0]       wr_addr;
    logic [pti_pkg::ADDR_W-1:0]       rd_addr;
    logic [pti_pkg::SAMPLE_WIDTH-1:0] r_rd;

    logic [pti_pkg::PT_W-1:0] r_a;
    logic [pti_pkg::PT_W-1:0] r_b;
    logic [pti_pkg::CH_W-1:0] r_ch;
    logic                     wr_in_range;

    assign wr_addr     = {i_in_data.channel, i_in_data.point_index};
    assign rd_addr     = {r_ch, i_cmd.rd_b ? r_b : r_a};
    assign wr_in_range = (32'(i_in_data.channel) < pti_pkg::NUM_ACTUATORS)
                      && (32'(i_in_data.point_index) < pti_pkg::CACHE_POINTS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            mem[wr_addr] <= i_in_data.point_value;
        end
        r_rd <= mem[rd_addr];
    end

    // timing
    logic [pti_pkg::TIME_W-1:0] r_len;
    logic [pti_pkg::PTS_W-1:0]  r_pts;
    logic [pti_pkg::ACT_W-1:0]  r_acts;
    logic [pti_pkg::TIME_W-1:0] r_now;
    logic [pti_pkg::TIME_W-1:0] r_start;
    logic                       r_known;
    logic [pti_pkg::TIME_W-1:0] r_e;
    logic [pti_pkg::PROD_W-1:0] r_p;
    logic [pti_pkg::FRAC_BITS-1:0] r_f;

    logic [pti_pkg::TIME_W-1:0] e_raw;

    // time before start counts as phase zero
    assign e_raw = (r_now >= r_start) ? (r_now - r_start) : '0;

    // shared divider
    logic                       div_start;
    logic [pti_pkg::TIME_W-1:0] div_init;
    logic [pti_pkg::TIME_W-1:0] div_bits;
    logic [pti_pkg::CNT_W-1:0]  div_count;
    logic                       div_done;
    logic [pti_pkg::TIME_W-1:0] div_quot;
    logic [pti_pkg::TIME_W-1:0] div_rem;

    // fraction pass divides (p << FRAC_BITS) by len; its quotient stays below
    // 2^QUOT_BITS, so p >> PT_W is already a valid partial remainder
    always_comb begin
        div_start = i_cmd.mod_start || i_cmd.frac_start;
        if (i_cmd.frac_start) begin
            div_init  = r_p[pti_pkg::PT_W+pti_pkg::TIME_W-1:pti_pkg::PT_W];
            div_bits  = {r_p[pti_pkg::PT_W-1:0], {(pti_pkg::TIME_W-pti_pkg::PT_W){1'b0}}};
            div_count = pti_pkg::CNT_W'(pti_pkg::QUOT_BITS);
        end else begin
            div_init  = '0;
            div_bits  = e_raw;
            div_count = pti_pkg::CNT_W'(pti_pkg::TIME_W);
        end
    end

    pti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_init_rem (div_init),
        .i_bits     (div_bits),
        .i_count    (div_count),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    logic [pti_pkg::PT_W-1:0]  q_a;
    logic [pti_pkg::PTS_W-1:0] a_next;

    assign q_a    = div_quot[pti_pkg::QUOT_BITS-1:pti_pkg::FRAC_BITS];
    assign a_next = pti_pkg::PTS_W'(q_a) + pti_pkg::PTS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_known <= 1'b0;
        end else begin
            if (i_cmd.take_time && !r_known) begin
                r_start <= i_in_data.now_time;
                r_known <= 1'b1;
            end else if (i_cmd.mod_load) begin
                // start + floor(e/len)*len == now - (e mod len)
                r_start <= r_now - div_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_time) begin
            r_now  <= i_in_data.now_time;
            r_len  <= len_sat;
            r_pts  <= pts_sat;
            r_acts <= acts_sat;
        end
        if (i_cmd.load_e) begin
            r_e <= e_raw;
        end else if (i_cmd.mod_load) begin
            r_e <= div_rem;
        end
        if (i_cmd.mul_p) begin
            r_p <= {{pti_pkg::PTS_W{1'b0}}, r_e} * {{pti_pkg::TIME_W{1'b0}}, r_pts};
        end
        if (i_cmd.frac_load) begin
            r_a <= q_a;
            r_b <= (a_next == r_pts) ? '0 : a_next[pti_pkg::PT_W-1:0];
            r_f <= div_quot[pti_pkg::FRAC_BITS-1:0];
        end
    end

    // interpolation: y = ya + ((yb - ya) * f + half) >> FRAC_BITS
    logic [pti_pkg::SAMPLE_WIDTH-1:0]         r_ya;
    logic signed [pti_pkg::MPROD_W-1:0]       r_prod;
    logic signed [pti_pkg::MIX_W-1:0]         mix_diff;
    logic signed [pti_pkg::MIX_W-1:0]         mix_frac;
    logic signed [pti_pkg::MPROD_W:0]         rnd_sum;
    logic [pti_pkg::MPROD_W-pti_pkg::FRAC_BITS:0] rnd_val;
    logic [pti_pkg::MPROD_W-pti_pkg::FRAC_BITS:0] y_full;
    logic                                     is_last;

    assign mix_diff = $signed({r_rd[pti_pkg::SAMPLE_WIDTH-1], r_rd})
                    - $signed({r_ya[pti_pkg::SAMPLE_WIDTH-1], r_ya});
    assign mix_frac = $signed({1'b0, r_f});
    assign rnd_sum  = $signed({r_prod[pti_pkg::MPROD_W-1], r_prod})
                    + $signed((pti_pkg::MPROD_W+1)'(1) <<< (pti_pkg::FRAC_BITS-1));
    assign rnd_val  = rnd_sum[pti_pkg::MPROD_W:pti_pkg::FRAC_BITS];
    assign y_full   = {{(pti_pkg::MPROD_W-pti_pkg::FRAC_BITS-pti_pkg::SAMPLE_WIDTH+1)
                        {r_ya[pti_pkg::SAMPLE_WIDTH-1]}}, r_ya} + rnd_val;
    assign is_last  = ((pti_pkg::ACT_W'(r_ch) + pti_pkg::ACT_W'(1)) == r_acts);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_b) begin
            r_ya <= r_rd;
        end
        if (i_cmd.mul) begin
            r_prod <= mix_diff * mix_frac;
        end
        if (i_cmd.frac_load) begin
            r_ch <= '0;
        end else if (i_cmd.out_load) begin
            r_ch <= r_ch + pti_pkg::CH_W'(1);
        end
    end

    // output register
    logic          r_out_valid;
    pti_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_channel  <= r_ch;
            r_out.drive_value  <= y_full[pti_pkg::SAMPLE_WIDTH-1:0];
            r_out.last_channel <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.e_ge_len = (e_raw >= r_len);
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.ch_last  = is_last;

    // wrapped elapsed time lies inside one cycle
    a_wrap_in_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_load |=> (r_e < r_len))
        else $error("wrapped elapsed time not below cycle length");

    // advanced start stays consistent with the wrapped elapsed time
    a_start_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_load |=> ((r_now - r_start) == r_e))
        else $error("cycle start and elapsed time disagree");

    // point pair lies inside the points in use and never collapses
    a_point_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.frac_load |=> ((pti_pkg::PTS_W'(r_a) < r_pts)
                          && (pti_pkg::PTS_W'(r_b) < r_pts) && (r_a != r_b)))
        else $error("interpolation points out of range");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

endmodule

`default_nettype wire

[hdl/pti_ctrl.sv]
// ----------------------------------------------------------------------------
// pti_ctrl: sequencer of the periodic table interpolator
// Accepts transactions in idle, steps the datapath through the wrap when needed,
// phase division and one read-multiply-emit pass per actuator.
// ----------------------------------------------------------------------------
`default_nettype none

module pti_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_command,
    output logic                  o_in_ready,
    output pti_pkg::t_cmd         o_cmd,
    input  wire pti_pkg::t_stat   i_stat
);

    pti_pkg::t_state r_state;
    pti_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pti_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_command == pti_pkg::CMD_TIME) begin
                        o_cmd.take_time = 1'b1;
                        n_state         = pti_pkg::S_ELAP;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            pti_pkg::S_ELAP: begin
                o_cmd.load_e = 1'b1;
                if (i_stat.e_ge_len) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = pti_pkg::S_MOD;
                end else begin
                    n_state = pti_pkg::S_MULP;
                end
            end
            pti_pkg::S_MOD: begin
                if (i_stat.div_done) begin
                    o_cmd.mod_load = 1'b1;
                    n_state        = pti_pkg::S_MULP;
                end
            end
            pti_pkg::S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = pti_pkg::S_PSTART;
            end
            pti_pkg::S_PSTART: begin
                o_cmd.frac_start = 1'b1;
                n_state          = pti_pkg::S_FRAC;
            end
            pti_pkg::S_FRAC: begin
                if (i_stat.div_done) begin
                    o_cmd.frac_load = 1'b1;
                    n_state         = pti_pkg::S_RDA;
                end
            end
            pti_pkg::S_RDA: begin
                n_state = pti_pkg::S_RDB;
            end
            pti_pkg::S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = pti_pkg::S_MUL;
            end
            pti_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = pti_pkg::S_OUT;
            end
            pti_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_stat.ch_last ? pti_pkg::S_IDLE : pti_pkg::S_RDA;
                end
            end
            default: begin
                n_state = pti_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/periodic_table_interpolator.sv]
// ----------------------------------------------------------------------------
// periodic_table_interpolator: multi-channel wavetable oscillator
// Per-actuator tables of signed Q1.15 samples spanning one cycle; each time
// transaction yields one linearly interpolated value per actuator in use.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  in       sink       i_in_valid/o_in_ready   t_in: command, channel, point,
//                                               sample, time
//  out      source     o_out_valid/i_out_ready t_out: channel, value, last
//  cfg      sink       i_cfg_we (no wait)      index, 32-bit data
//
//  Sequence: a write transaction is stored in idle; input is taken only in
//  idle. A time transaction runs the wrap division only when elapsed time
//  has reached one cycle length, then the point index and fraction division
//  (32 and 23 quotient bits on the bit-serial divider), then the states RDA,
//  RDB, MUL and OUT per actuator on the single table read port.
//  Reset: synchronous, active low; clears the controller and the start-time
//  latch, sets the config defaults. Table contents are undefined until written.
//  Stalls: a held result only stops the sequencer at its emit step; input is
//  taken again once the last actuator's result is in the output register.
//
`default_nettype none

module periodic_table_interpolator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [pti_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pti_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input transactions
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire pti_pkg::t_in                    i_in_data,
    // result transactions
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output pti_pkg::t_out                        o_out_data
);

    // command and status between sequencer and datapath
    pti_pkg::t_cmd  cmd;
    pti_pkg::t_stat stat;

    pti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // table, timing, divider, interpolator and output register
    pti_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
